[hdl/twfra_pkg.sv]
// package for the frame rate averager: widths, controller states and the
// command/status structs shared by controller and datapath. no dependencies
package twfra_pkg;

  localparam int RingDepth = 256;
  localparam int IdxW      = $clog2(RingDepth);
  localparam int CntW      = IdxW + 1;
  localparam int TimeW     = 63;
  localparam int WinW      = 40;
  localparam int SpanCfgW  = 20;
  localparam int SumW      = 32 + CntW;
  localparam int NumW      = 96;

  localparam logic [63:0] NsPerSecQ16 = 64'd65536000000000;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // config register indexes
  localparam logic CFG_WINDOW   = 1'b0;
  localparam logic CFG_MIN_SPAN = 1'b1;

  localparam logic [31:0] ReadyZero = 32'd0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DROP,
    ST_WRITE,
    ST_EVRD,
    ST_EVCHK,
    ST_DIV_SETUP,
    ST_DIV_RUN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load_item;
    logic clear_all;
    logic drop_head;
    logic write_tail;
    logic read_head;
    logic div_start;
    logic div_step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic changed;
    logic ring_full;
    logic evict;
    logic div_done;
  } dp_sts_t;

endpackage

[hdl/twfra_datapath.sv]
// datapath: ring memories, head/count, running sum, two shared-cycle
// restoring dividers. depends on twfra_pkg
module twfra_datapath (
  input  logic                    clk,
  input  logic                    rst_n,
  input  twfra_pkg::dp_cmd_t      cmd,
  output twfra_pkg::dp_sts_t      sts,
  input  logic                    in_command,
  input  logic [31:0]             in_rate,
  input  logic [31:0]             in_render,
  input  logic [62:0]             in_time,
  input  logic [39:0]             window_length_ns,
  input  logic [19:0]             min_span_ns,
  output logic [31:0]             res_current_rate,
  output logic [31:0]             res_average_rate,
  output logic [31:0]             res_current_render,
  output logic [31:0]             res_average_render,
  output logic                    res_was_cleared
);
  import twfra_pkg::*;

  logic [TimeW-1:0] time_mem [RingDepth];
  logic [31:0]      rend_mem [RingDepth];

  logic [IdxW-1:0]  head_r, head_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic [SumW-1:0]  sum_r, sum_nxt;
  logic [31:0]      last_rate_r, last_render_r, avg_rate_r, avg_render_r;
  logic             cmd_r;
  logic [31:0]      rate_r, rend_r;
  logic [TimeW-1:0] t_r;
  logic [TimeW-1:0] head_time_r;
  logic [31:0]      head_rend_r;
  logic [7:0]       div_cnt_r;
  // rate divider
  logic [NumW-1:0]  rq_r;
  logic [TimeW:0]   rrem_r;
  logic [TimeW-1:0] rden_r;
  logic             rate_fb_r;
  // render divider
  logic [SumW-1:0]  sq_r;
  logic [CntW:0]    srem_r;
  logic             wc_r;

  logic [IdxW-1:0]  tail;
  logic [TimeW+1:0] evict_lhs;
  logic [TimeW:0]   rrem_sh, rrem_sub;
  logic [CntW:0]    srem_sh, srem_sub;
  logic [TimeW-1:0] span;
  logic [NumW-1:0]  numer;

  assign tail = head_r + count_r[IdxW-1:0];
  assign evict_lhs = {2'b00, head_time_r} + {{(TimeW+2-WinW){1'b0}}, window_length_ns};
  assign span = t_r - head_time_r;
  assign numer = NumW'(count_r - CntW'(1)) * NumW'(NsPerSecQ16);
  assign rrem_sh = {rrem_r[TimeW-1:0], rq_r[NumW-1]};
  assign rrem_sub = rrem_sh - {1'b0, rden_r};
  assign srem_sh = {srem_r[CntW-1:0], sq_r[SumW-1]};
  assign srem_sub = srem_sh - {1'b0, count_r};

  assign sts.is_clear = cmd_r;
  assign sts.changed = (last_rate_r != ReadyZero) || (avg_rate_r != ReadyZero) ||
    (last_render_r != ReadyZero) || (avg_render_r != ReadyZero) ||
    (count_r != '0) || (sum_r != '0);
  assign sts.ring_full = (count_r == CntW'(RingDepth));
  assign sts.evict = (count_r != '0) && (evict_lhs < {2'b00, t_r});
  assign sts.div_done = (div_cnt_r == 8'd0);

  always_comb begin
    head_nxt = head_r;
    count_nxt = count_r;
    sum_nxt = sum_r;
    if (cmd.clear_all) begin
      head_nxt = '0; count_nxt = '0; sum_nxt = '0;
    end else if (cmd.drop_head) begin
      head_nxt = head_r + IdxW'(1);
      count_nxt = count_r - CntW'(1);
      sum_nxt = sum_r - SumW'(head_rend_r);
    end else if (cmd.write_tail) begin
      count_nxt = count_r + CntW'(1);
      sum_nxt = sum_r + SumW'(rend_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_tail) begin
      time_mem[tail] <= t_r;
      rend_mem[tail] <= rend_r;
    end
    if (cmd.read_head) begin
      head_time_r <= time_mem[head_r];
      head_rend_r <= rend_mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0; count_r <= '0; sum_r <= '0;
      last_rate_r <= '0; last_render_r <= '0;
      avg_rate_r <= '0; avg_render_r <= '0;
      cmd_r <= 1'b0; div_cnt_r <= '0;
    end else begin
      head_r <= head_nxt;
      count_r <= count_nxt;
      sum_r <= sum_nxt;
      if (cmd.load_item) begin
        cmd_r <= in_command;
        rate_r <= in_rate;
        rend_r <= in_render;
        t_r <= in_time;
      end
      if (cmd.clear_all) begin
        last_rate_r <= '0; last_render_r <= '0;
        avg_rate_r <= '0; avg_render_r <= '0;
        wc_r <= 1'b1;
      end
      if (cmd.div_start) begin
        // head_time_r holds the front after the final eviction check
        rate_fb_r <= (count_r < CntW'(2)) || (t_r <= head_time_r) ||
                     (span <= {{(TimeW-SpanCfgW){1'b0}}, min_span_ns});
        rq_r <= numer;
        rrem_r <= '0;
        rden_r <= span;
        sq_r <= sum_r;
        srem_r <= '0;
        div_cnt_r <= 8'(NumW);
      end else if (cmd.div_step) begin
        if (!rrem_sub[TimeW]) begin
          rrem_r <= rrem_sub; rq_r <= {rq_r[NumW-2:0], 1'b1};
        end else begin
          rrem_r <= rrem_sh; rq_r <= {rq_r[NumW-2:0], 1'b0};
        end
        if (div_cnt_r <= 8'(SumW)) begin
          if (!srem_sub[CntW]) begin
            srem_r <= srem_sub; sq_r <= {sq_r[SumW-2:0], 1'b1};
          end else begin
            srem_r <= srem_sh; sq_r <= {sq_r[SumW-2:0], 1'b0};
          end
        end
        div_cnt_r <= div_cnt_r - 8'd1;
      end
      if (cmd.finish) begin
        last_rate_r <= rate_r;
        last_render_r <= rend_r;
        wc_r <= 1'b0;
        if (rate_fb_r) avg_rate_r <= rate_r;
        else avg_rate_r <= (rq_r[NumW-1:32] != '0) ? 32'hFFFF_FFFF : rq_r[31:0];
        avg_render_r <= (sq_r[SumW-1:32] != '0) ? 32'hFFFF_FFFF : sq_r[31:0];
      end
    end
  end

  assign res_current_rate = last_rate_r;
  assign res_average_rate = avg_rate_r;
  assign res_current_render = last_render_r;
  assign res_average_render = avg_render_r;
  assign res_was_cleared = wc_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(RingDepth)) else $error("ring count overflow");
  a_write_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write_tail |-> !sts.ring_full) else $error("write into full ring");
  a_drop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drop_head |-> count_r != '0) else $error("drop from empty ring");
`endif
endmodule

[hdl/twfra_ctrl.sv]
// controller state machine: sequences clear, record, eviction walk and division
// depends on twfra_pkg
module twfra_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output twfra_pkg::dp_cmd_t cmd,
  input  twfra_pkg::dp_sts_t sts
);
  import twfra_pkg::*;

  state_t state_r, state_nxt;
  logic   ovalid_r, ovalid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ovalid_r <= ovalid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    ovalid_nxt = ovalid_r && !out_ready;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load_item = in_fire;
        cmd.read_head = 1'b1;
        if (in_fire) state_nxt = ST_CLEAR;
      end
      ST_CLEAR: begin
        if (sts.is_clear) begin
          if (sts.changed) begin
            if (!ovalid_nxt) begin
              cmd.clear_all = 1'b1; ovalid_nxt = 1'b1; state_nxt = ST_IDLE;
            end
          end else begin
            cmd.clear_all = 1'b1; state_nxt = ST_IDLE;
          end
        end else if (sts.ring_full) begin
          cmd.drop_head = 1'b1; state_nxt = ST_WRITE;
        end else state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.write_tail = 1'b1; state_nxt = ST_EVRD;
      end
      ST_EVRD: begin
        cmd.read_head = 1'b1; state_nxt = ST_EVCHK;
      end
      ST_EVCHK: begin
        if (sts.evict) begin
          cmd.drop_head = 1'b1; state_nxt = ST_EVRD;
        end else begin
          cmd.div_start = 1'b1; state_nxt = ST_DIV_RUN;
        end
      end
      ST_DIV_RUN: begin
        if (sts.div_done) state_nxt = ST_OUT;
        else cmd.div_step = 1'b1;
      end
      ST_OUT: begin
        if (!ovalid_nxt) begin
          cmd.finish = 1'b1; ovalid_nxt = 1'b1; state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = ovalid_r;

`ifndef ASSERT_OFF
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == ST_IDLE) else $error("ready outside idle");
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !out_valid || out_ready) else $error("result overwritten");
`endif
endmodule

[hdl/time_window_frame_rate_averager_unit.sv]
// top level of the time-window frame rate averager: config registers,
// controller and datapath. depends on twfra_pkg, twfra_ctrl, twfra_datapath
//
// channel  dir  contents
// in_      in   tuser=command, tdata=frame_rate,frame_render_ms,frame_end_time
// out_     out  tuser=was_cleared, tdata=current_rate,average_rate,cur/avg render
// cfg_     in   index 0 window_length_ns, index 1 min_span_ns
//
// a record runs the drop if full, the tail write, the eviction walk (read, then
// check each head entry) and the 96-step divider; a clear returns to idle
// one item in flight; the result register lets the next item in while it waits
// reset is synchronous; ring memories need no clearing
module time_window_frame_rate_averager_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,  // frame_rate, frame_render_ms, frame_end_time, pad
  input  logic         in_tuser,  // command
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata, // current_rate, average_rate, current_render, avg_render
  output logic         out_tuser, // was_cleared
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [39:0]  cfg_wdata
);
  import twfra_pkg::*;

  logic [39:0] window_r;
  logic [19:0] min_span_r;
  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic        out_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= 40'd1000000000; min_span_r <= 20'd1000;
    end else if (cfg_we) begin
      if (cfg_index == CFG_WINDOW) window_r <= cfg_wdata;
      else min_span_r <= cfg_wdata[19:0];
    end
  end

  twfra_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_tvalid && in_tready),
    .in_ready(in_tready), .out_valid(out_valid), .out_ready(out_tready),
    .cmd(cmd), .sts(sts));

  twfra_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_command(in_tuser), .in_rate(in_tdata[31:0]),
    .in_render(in_tdata[63:32]), .in_time(in_tdata[126:64]),
    .window_length_ns(window_r), .min_span_ns(min_span_r),
    .res_current_rate(out_tdata[31:0]), .res_average_rate(out_tdata[63:32]),
    .res_current_render(out_tdata[95:64]), .res_average_render(out_tdata[127:96]),
    .res_was_cleared(out_tuser));

  assign out_tvalid = out_valid;
endmodule
